// ----- rtl/mvsm_pkg.sv -----
// Shared constants, action codes and the voice record for the sample mixer.
`default_nettype none

package mvsm_pkg;

  localparam int FRAC_BITS   = 10;
  localparam int FRAMES_W    = 17;
  localparam int PHASE_W     = FRAMES_W + FRAC_BITS;
  localparam int STEP_W      = 18;
  localparam int START_W     = 16;
  localparam int SAMPLE_W    = 16;
  localparam int GAIN_W      = 16;
  localparam int MASK_W      = 8;
  localparam int SCALE_SHIFT = 15;
  localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;
  // start + 2 * index + 1 fits here
  localparam int ADDR_SUM_W  = FRAMES_W + 2;

  localparam int DEF_NUM_VOICES   = 8;
  localparam int DEF_SAMPLE_WORDS = 65536;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_PROGRAM = 2'd1;
  localparam logic [1:0] ACT_STOP    = 2'd2;
  localparam logic [1:0] ACT_MIX     = 2'd3;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'h8000;

  typedef struct packed {
    logic [PHASE_W-1:0]  phase;
    logic                done;
    logic                paused;
    logic                loops;
    logic                stereo;
    logic [START_W-1:0]  start;
    logic [FRAMES_W-1:0] frames;
    logic [STEP_W-1:0]   incr;
    logic [GAIN_W-1:0]   lgain;
    logic [GAIN_W-1:0]   rgain;
  } voice_t;

  localparam voice_t VOICE_RESET = '{
    phase:  '0,
    done:   1'b1,
    paused: 1'b0,
    loops:  1'b0,
    stereo: 1'b0,
    start:  '0,
    frames: 17'd1,
    incr:   '0,
    lgain:  UNITY_GAIN,
    rgain:  UNITY_GAIN
  };

endpackage

`default_nettype wire

// ----- rtl/mvsm_if.sv -----
// Valid/ready channel interfaces for mixer commands and mixed frames.
`default_nettype none

interface mvsm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [2:0]         voice;
  logic [15:0]        sample_addr;
  logic signed [15:0] sample_value;
  logic [16:0]        length;
  logic               stereo;
  logic               looping;
  logic [17:0]        step;
  logic [15:0]        left_gain;
  logic [15:0]        right_gain;
  logic               restart;
  logic               paused;

  modport source (
    output valid, action, voice, sample_addr, sample_value, length, stereo, looping,
           step, left_gain, right_gain, restart, paused,
    input  ready
  );
  modport sink (
    input  valid, action, voice, sample_addr, sample_value, length, stereo, looping,
           step, left_gain, right_gain, restart, paused,
    output ready
  );
endinterface

interface mvsm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;
  logic [7:0]         done_mask;

  modport source (output valid, left_out, right_out, done_mask, input ready);
  modport sink   (input  valid, left_out, right_out, done_mask, output ready);
endinterface

`default_nettype wire

// ----- rtl/mvsm_sample_store.sv -----
// PCM sample memory: one write port, two registered read ports.
`default_nettype none

module mvsm_sample_store #(
  parameter  int SAMPLE_WORDS = mvsm_pkg::DEF_SAMPLE_WORDS,
  localparam int AW           = $clog2(SAMPLE_WORDS)
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [AW-1:0]                 waddr_i,
  input  wire logic [mvsm_pkg::SAMPLE_W-1:0] wdata_i,
  input  wire logic [AW-1:0]                 raddr_a_i,
  input  wire logic [AW-1:0]                 raddr_b_i,
  output logic      [mvsm_pkg::SAMPLE_W-1:0] rdata_a_o,
  output logic      [mvsm_pkg::SAMPLE_W-1:0] rdata_b_o
);
  import mvsm_pkg::*;

  logic [SAMPLE_W-1:0] mem [SAMPLE_WORDS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

// ----- rtl/mvsm_voice_table.sv -----
// Per-voice state memory with valid bits so unwritten entries read as reset state.
`default_nettype none

module mvsm_voice_table #(
  parameter  int NUM_VOICES = mvsm_pkg::DEF_NUM_VOICES,
  localparam int VIW        = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [VIW-1:0]   raddr_i,
  output mvsm_pkg::voice_t      rdata_o,
  input  wire logic             we_i,
  input  wire logic [VIW-1:0]   waddr_i,
  input  wire mvsm_pkg::voice_t wdata_i
);
  import mvsm_pkg::*;

  voice_t                mem [NUM_VOICES];
  voice_t                rd_q;
  logic                  rd_valid_q;
  logic [NUM_VOICES-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rd_valid_q ? rd_q : VOICE_RESET;

endmodule

`default_nettype wire

// ----- rtl/mvsm_mod_unit.sv -----
// Bit-serial remainder unit that folds a phase back into its loop span.
`default_nettype none

module mvsm_mod_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [mvsm_pkg::PHASE_W:0]   dividend_i,
  input  wire logic [mvsm_pkg::PHASE_W-1:0] divisor_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic      [mvsm_pkg::PHASE_W-1:0] rem_o
);
  import mvsm_pkg::*;

  localparam int CW = $clog2(PHASE_W + 1);

  logic [CW-1:0]      cnt_q;
  logic [PHASE_W:0]   quo_q;
  logic [PHASE_W:0]   rem_q;
  logic [PHASE_W:0]   rem_sh;
  logic [PHASE_W-1:0] div_q;
  logic               busy_q;
  logic               done_q;

  // shift in the next dividend bit
  assign rem_sh = {rem_q[PHASE_W-1:0], quo_q[PHASE_W]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        quo_q  <= dividend_i;
        div_q  <= divisor_i;
        cnt_q  <= CW'(PHASE_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        quo_q <= {quo_q[PHASE_W-1:0], 1'b0};
        if (rem_sh >= {1'b0, div_q}) begin
          rem_q <= rem_sh - {1'b0, div_q};
        end else begin
          rem_q <= rem_sh;
        end
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q[PHASE_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/multi_voice_sample_mixer.sv -----
// Sample playback mixer: a sequencer walks the voice table and mixes from the sample store.
//
// One command transaction is handled at a time. A sample write goes straight to the store; a
// program or stop reads the voice entry, then writes it back. A mix walks the voices in
// order through the voice table, whose read is registered: a paused or finished voice
// passes through voice read, check and write-back, a playing voice through voice read,
// check, dual sample read, multiply, accumulate and write-back, and every phase wrap adds
// a pass through the bit-serial remainder unit, which retires one phase bit per cycle. The
// result sits in an output register, so the next command is taken while a frame waits to
// be collected. SAMPLE_WORDS must be a power of two; store addresses wrap at that size,
// and a store word must be written before any voice plays it. Voice state resets to
// stopped, unity gain, one frame long.
`default_nettype none

module multi_voice_sample_mixer #(
  parameter int NUM_VOICES   = mvsm_pkg::DEF_NUM_VOICES,
  parameter int SAMPLE_WORDS = mvsm_pkg::DEF_SAMPLE_WORDS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mvsm_in_if.sink    in_i,
  mvsm_out_if.source out_o
);
  import mvsm_pkg::*;

  localparam int VIW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int XW  = (VIW > 3) ? VIW : 3;
  localparam int AW  = $clog2(SAMPLE_WORDS);
  localparam int EW  = (AW > ADDR_SUM_W) ? AW : ADDR_SUM_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CMD, S_VREAD, S_VEVAL, S_WRAP1, S_SREAD, S_MUL, S_ACC, S_WRAP2, S_WB, S_OUT
  } state_e;

  state_e            state_q;
  voice_t            cmd_q;
  logic              cmd_restart_q;
  logic              cmd_stop_q;
  logic [VIW-1:0]    cmd_idx_q;
  logic [VIW-1:0]    vcnt_q;
  voice_t            ent_q;
  logic [PHASE_W:0]  ph_q;
  logic [15:0]       sum_l_q;
  logic [15:0]       sum_r_q;
  logic [15:0]       scl_l_q;
  logic [15:0]       scl_r_q;
  logic [MASK_W-1:0] mask_q;
  logic              out_valid_q;
  logic [15:0]       out_l_q;
  logic [15:0]       out_r_q;
  logic [MASK_W-1:0] out_mask_q;

  logic              in_accept;
  logic              voice_ok;
  logic [XW-1:0]     in_vx;
  logic [VIW-1:0]    in_idx;
  logic              store_we;
  logic [EW-1:0]     store_waddr;

  voice_t            vt_rdata;
  voice_t            vt_wdata;
  voice_t            cmd_wdata;
  voice_t            wb_wdata;
  voice_t            ev_ent;
  logic              vt_we;
  logic [VIW-1:0]    vt_waddr;
  logic [VIW-1:0]    vt_raddr;

  logic [PHASE_W-1:0] span_rd;
  logic [PHASE_W-1:0] span_ent;
  logic               ev_skip;
  logic               ev_empty;
  logic               ev_over;
  logic               ev_end;
  logic [PHASE_W:0]   ph_next;
  logic               acc_over;

  logic               mod_start;
  logic               mod_busy;
  logic               mod_done;
  logic [PHASE_W:0]   mod_dividend;
  logic [PHASE_W-1:0] mod_divisor;
  logic [PHASE_W-1:0] mod_rem;

  logic [FRAMES_W-1:0] idx;
  logic [FRAMES_W:0]   off;
  logic [EW-1:0]       sum_addr_l;
  logic [EW-1:0]       sum_addr_r;
  logic [SAMPLE_W-1:0] rd_l;
  logic [SAMPLE_W-1:0] rd_r;
  logic signed [SAMPLE_W-1:0] samp_l;
  logic signed [SAMPLE_W-1:0] samp_r;
  logic signed [PROD_W-1:0]   prod_l;
  logic signed [PROD_W-1:0]   prod_r;

  // command side
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_accept   = in_i.valid && in_i.ready;
  assign voice_ok    = int'(in_i.voice) < NUM_VOICES;
  assign in_vx       = XW'(in_i.voice);
  assign in_idx      = in_vx[VIW-1:0];
  assign store_we    = in_accept && (in_i.action == ACT_WRITE);
  assign store_waddr = EW'(in_i.sample_addr);

  // voice table access
  assign vt_raddr = (state_q == S_IDLE) ? in_idx : vcnt_q;

  always_comb begin
    cmd_wdata = cmd_q;
    if (cmd_stop_q) begin
      cmd_wdata      = vt_rdata;
      cmd_wdata.done = 1'b1;
    end else if (!cmd_restart_q) begin
      cmd_wdata.phase = vt_rdata.phase;
      cmd_wdata.done  = vt_rdata.done;
    end
    wb_wdata       = ent_q;
    wb_wdata.phase = ph_q[PHASE_W-1:0];
    // a voice that ends at the check goes straight to write-back as done
    ev_ent = vt_rdata;
    if (ev_end) begin
      ev_ent.done = 1'b1;
    end
  end

  assign vt_we    = (state_q == S_CMD) || (state_q == S_WB);
  assign vt_waddr = (state_q == S_CMD) ? cmd_idx_q : vcnt_q;
  assign vt_wdata = (state_q == S_CMD) ? cmd_wdata : wb_wdata;

  // voice checks and phase advance
  assign span_rd  = {vt_rdata.frames, {FRAC_BITS{1'b0}}};
  assign span_ent = {ent_q.frames, {FRAC_BITS{1'b0}}};
  assign ev_skip  = vt_rdata.paused || vt_rdata.done;
  assign ev_empty = (vt_rdata.frames == '0);
  assign ev_over  = (vt_rdata.phase >= span_rd);
  assign ev_end   = !ev_skip && (ev_empty || (ev_over && !vt_rdata.loops));
  assign ph_next  = {1'b0, ph_q[PHASE_W-1:0]} + (PHASE_W + 1)'(ent_q.incr);
  assign acc_over = (ph_next >= {1'b0, span_ent});

  assign mod_start = ((state_q == S_VEVAL) && !ev_skip && !ev_empty && ev_over
                      && vt_rdata.loops)
                  || ((state_q == S_ACC) && acc_over && ent_q.loops);
  assign mod_dividend = (state_q == S_ACC) ? ph_next : {1'b0, vt_rdata.phase};
  assign mod_divisor  = (state_q == S_ACC) ? span_ent : span_rd;

  // sample addresses: mono reads one word twice, stereo reads the interleaved pair
  assign idx        = ph_q[PHASE_W-1:FRAC_BITS];
  assign off        = ent_q.stereo ? {idx, 1'b0} : {1'b0, idx};
  assign sum_addr_l = EW'(ent_q.start) + EW'(off);
  assign sum_addr_r = sum_addr_l + EW'(ent_q.stereo);

  assign samp_l = rd_l;
  assign samp_r = rd_r;
  assign prod_l = samp_l * $signed({1'b0, ent_q.lgain});
  assign prod_r = samp_r * $signed({1'b0, ent_q.rgain});

  mvsm_sample_store #(
    .SAMPLE_WORDS (SAMPLE_WORDS)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (store_we),
    .waddr_i   (store_waddr[AW-1:0]),
    .wdata_i   (in_i.sample_value),
    .raddr_a_i (sum_addr_l[AW-1:0]),
    .raddr_b_i (sum_addr_r[AW-1:0]),
    .rdata_a_o (rd_l),
    .rdata_b_o (rd_r)
  );

  mvsm_voice_table #(
    .NUM_VOICES (NUM_VOICES)
  ) u_voices (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (vt_raddr),
    .rdata_o (vt_rdata),
    .we_i    (vt_we),
    .waddr_i (vt_waddr),
    .wdata_i (vt_wdata)
  );

  mvsm_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .divisor_i  (mod_divisor),
    .busy_o     (mod_busy),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cmd_q         <= VOICE_RESET;
      cmd_restart_q <= 1'b0;
      cmd_stop_q    <= 1'b0;
      cmd_idx_q     <= '0;
      vcnt_q        <= '0;
      ent_q         <= VOICE_RESET;
      ph_q          <= '0;
      sum_l_q       <= '0;
      sum_r_q       <= '0;
      scl_l_q       <= '0;
      scl_r_q       <= '0;
      mask_q        <= '0;
      out_valid_q   <= 1'b0;
      out_l_q       <= '0;
      out_r_q       <= '0;
      out_mask_q    <= '0;
    end else begin
      // the output step handles the hand-off itself
      if (out_valid_q && out_o.ready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            cmd_q.phase   <= '0;
            cmd_q.done    <= 1'b0;
            cmd_q.paused  <= in_i.paused;
            cmd_q.loops   <= in_i.looping;
            cmd_q.stereo  <= in_i.stereo;
            cmd_q.start   <= in_i.sample_addr;
            cmd_q.frames  <= in_i.length;
            cmd_q.incr    <= in_i.step;
            cmd_q.lgain   <= in_i.left_gain;
            cmd_q.rgain   <= in_i.right_gain;
            cmd_restart_q <= in_i.restart;
            cmd_stop_q    <= (in_i.action == ACT_STOP);
            cmd_idx_q     <= in_idx;
            unique case (in_i.action) inside
              ACT_PROGRAM, ACT_STOP: begin
                if (voice_ok) begin
                  state_q <= S_CMD;
                end
              end
              ACT_MIX: begin
                vcnt_q  <= '0;
                sum_l_q <= '0;
                sum_r_q <= '0;
                mask_q  <= '0;
                state_q <= S_VREAD;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_CMD: begin
          state_q <= S_IDLE;
        end
        S_VREAD: begin
          state_q <= S_VEVAL;
        end
        S_VEVAL: begin
          ent_q <= ev_ent;
          ph_q  <= {1'b0, vt_rdata.phase};
          if (ev_skip || ev_end) begin
            state_q <= S_WB;
          end else if (ev_over) begin
            state_q <= S_WRAP1;
          end else begin
            state_q <= S_SREAD;
          end
        end
        S_WRAP1: begin
          if (mod_done) begin
            ph_q    <= {1'b0, mod_rem};
            state_q <= S_SREAD;
          end
        end
        S_SREAD: begin
          state_q <= S_MUL;
        end
        S_MUL: begin
          scl_l_q <= prod_l[SCALE_SHIFT+SAMPLE_W-1:SCALE_SHIFT];
          scl_r_q <= prod_r[SCALE_SHIFT+SAMPLE_W-1:SCALE_SHIFT];
          state_q <= S_ACC;
        end
        S_ACC: begin
          sum_l_q <= sum_l_q + scl_l_q;
          sum_r_q <= sum_r_q + scl_r_q;
          ph_q    <= ph_next;
          if (acc_over && ent_q.loops) begin
            state_q <= S_WRAP2;
          end else begin
            if (acc_over) begin
              ent_q.done <= 1'b1;
            end
            state_q <= S_WB;
          end
        end
        S_WRAP2: begin
          if (mod_done) begin
            ph_q    <= {1'b0, mod_rem};
            state_q <= S_WB;
          end
        end
        S_WB: begin
          if (int'(vcnt_q) < MASK_W) begin
            mask_q[vcnt_q] <= ent_q.done;
          end
          if (vcnt_q == VIW'(NUM_VOICES - 1)) begin
            state_q <= S_OUT;
          end else begin
            vcnt_q  <= vcnt_q + 1'b1;
            state_q <= S_VREAD;
          end
        end
        S_OUT: begin
          // hold until the previous frame has been taken
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_l_q     <= sum_l_q;
            out_r_q     <= sum_r_q;
            out_mask_q  <= mask_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.left_out  = out_l_q;
  assign out_o.right_out = out_r_q;
  assign out_o.done_mask = out_mask_q;

`ifndef SYNTHESIS
  a_store_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_we |-> (state_q == S_IDLE) && !mod_busy)
    else $error("sample store written during a mix");

  a_mod_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_start |-> !mod_busy)
    else $error("remainder unit restarted while busy");

  a_frame_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(state_q == S_OUT))
    else $error("frame published outside the output step");

  a_mask_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.done_mask >> NUM_VOICES) == '0))
    else $error("done bit set for a voice that does not exist");
`endif

endmodule

`default_nettype wire
